>>> sv/tcw_pkg.sv
package tcw_pkg;

   localparam int COLS_DEF     = 80;
   localparam int ROWS_DEF     = 25;
   localparam int CONSOLES_DEF = 8;

   localparam int CON_IDX_W = 3;
   localparam int RD_ADDR_W = 14;
   localparam int CHAR_W    = 8;
   localparam int COLOR_W   = 4;
   localparam int CELL_W    = CHAR_W + 2 * COLOR_W;

   // depth must be a power of two, pointers wrap naturally
   localparam int QUEUE_DEPTH = 2;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   localparam logic [CHAR_W-1:0] CHR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHR_BACK    = 8'h08;
   localparam logic [CHAR_W-1:0] CHR_DEL     = 8'h7F;
   localparam logic [CHAR_W-1:0] CHR_SPACE   = 8'h20;

   // high nibble of the color-setting codes
   localparam logic [3:0] FG_GROUP = 4'h0;
   localparam logic [3:0] BG_GROUP = 4'h1;

   localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
   localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;
   localparam logic [CELL_W-1:0]  BLANK_CELL = {BG_RESET, FG_RESET, CHR_SPACE};

   typedef enum logic [2:0] {
      OP_NONE,
      OP_READ,
      OP_NEWLINE,
      OP_DEL,
      OP_BACK,
      OP_FG,
      OP_BG,
      OP_PUT
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [CON_IDX_W-1:0]  con;
      logic [CHAR_W-1:0]     chr;
      logic                  last;
      logic [RD_ADDR_W-1:0]  addr;
   } cmd_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_PREP,
      S_CELL_ADDR,
      S_DEL_RD,
      S_DEL_WR,
      S_PUT_WR,
      S_SCROLL,
      S_CURSOR,
      S_RESP
   } back_state_type;

endpackage

>>> sv/tcw_front.sv
module tcw_front #(
   parameter int CONSOLES = tcw_pkg::CONSOLES_DEF
) (
   input  logic                             start,
   input  logic                             busy,
   input  logic                             req_func,
   input  logic [tcw_pkg::CON_IDX_W-1:0]    req_console_index,
   input  logic [tcw_pkg::CHAR_W-1:0]       req_data_byte,
   input  logic                             req_last_of_write,
   input  logic [tcw_pkg::RD_ADDR_W-1:0]    req_read_address,
   output logic                             push,
   output tcw_pkg::cmd_type                 cmd
);
   import tcw_pkg::*;

   logic con_ok;

   assign push   = start & ~busy;
   assign con_ok = int'(req_console_index) < CONSOLES;

   always_comb begin
      cmd.con  = req_console_index;
      cmd.chr  = req_data_byte;
      cmd.last = req_last_of_write;
      cmd.addr = req_read_address;
      if (req_func == FUNC_READ) begin
         cmd.op = OP_READ;
      end else if (!con_ok) begin
         cmd.op = OP_NONE;
      end else if (req_data_byte == CHR_NEWLINE) begin
         cmd.op = OP_NEWLINE;
      end else if (req_data_byte == CHR_DEL) begin
         cmd.op = OP_DEL;
      end else if (req_data_byte == CHR_BACK) begin
         cmd.op = OP_BACK;
      end else if (req_data_byte[7:4] == FG_GROUP) begin
         cmd.op = OP_FG;
      end else if (req_data_byte[7:4] == BG_GROUP) begin
         cmd.op = OP_BG;
      end else begin
         cmd.op = OP_PUT;
      end
   end

endmodule

>>> sv/tcw_queue.sv
module tcw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcw_pkg::cmd_type  push_cmd,
   input  logic              pop,
   output tcw_pkg::cmd_type  head_cmd,
   output logic              empty,
   output logic              full
);
   import tcw_pkg::*;

   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   cmd_type        slot_ff [QUEUE_DEPTH];
   logic [QW-1:0]  wr_ptr_ff;
   logic [QW-1:0]  rd_ptr_ff;
   logic [QW:0]    count_ff;
   logic           do_push;
   logic           do_pop;

   assign empty    = count_ff == '0;
   assign full     = count_ff == (QW+1)'(QUEUE_DEPTH);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QW'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + QW'(1);
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (QW+1)'(1);
         end else if (!do_push && do_pop) begin
            count_ff <= count_ff - (QW+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

>>> sv/tcw_back.sv
module tcw_back #(
   parameter int COLS     = tcw_pkg::COLS_DEF,
   parameter int ROWS     = tcw_pkg::ROWS_DEF,
   parameter int CONSOLES = tcw_pkg::CONSOLES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tcw_pkg::cmd_type                q_cmd,
   input  logic                            q_empty,
   output logic                            q_pop,
   output logic                            clearing,
   output logic                            rsp_strobe,
   output logic [tcw_pkg::RD_ADDR_W-1:0]   rsp_cursor_offset,
   output logic                            rsp_cursor_update,
   output logic [tcw_pkg::CHAR_W-1:0]      rsp_read_char,
   output logic [tcw_pkg::COLOR_W-1:0]     rsp_read_fg,
   output logic [tcw_pkg::COLOR_W-1:0]     rsp_read_bg
);
   import tcw_pkg::*;

   localparam int SCREEN_CELLS = COLS * ROWS;
   localparam int STORE_CELLS  = SCREEN_CELLS * CONSOLES;
   localparam int MOVED        = SCREEN_CELLS - COLS;
   localparam int AW    = $clog2(STORE_CELLS);
   localparam int XW    = (AW > RD_ADDR_W) ? AW : RD_ADDR_W;
   localparam int SW    = $clog2(SCREEN_CELLS + 1);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLS);
   localparam int CON_W = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;

   back_state_type     state_ff;
   back_state_type     state_in;

   logic [CELL_W-1:0]  store_mem [STORE_CELLS];
   logic [CELL_W-1:0]  rd_data_ff;
   logic               mem_re;
   logic [AW-1:0]      mem_raddr;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [CELL_W-1:0]  mem_wdata;

   logic [RW-1:0]      cur_row_ff [CONSOLES];
   logic [CW-1:0]      cur_col_ff [CONSOLES];
   logic [COLOR_W-1:0] fg_ff [CONSOLES];
   logic [COLOR_W-1:0] bg_ff [CONSOLES];

   cmd_type            cmd_ff;
   logic [AW-1:0]      base_ff;
   logic [RW-1:0]      row_w_ff;
   logic [CW-1:0]      col_w_ff;
   logic [AW-1:0]      cell_ff;
   logic [AW-1:0]      clr_ff;
   logic               rd_ok_ff;

   logic [SW-1:0]      i_ff;
   logic [AW-1:0]      src_ff;
   logic [AW-1:0]      dst_ff;
   logic [AW-1:0]      pdst_ff;
   logic               pblank_ff;
   logic               pend_ff;

   logic [CON_W-1:0]   q_idx;
   logic [CON_W-1:0]   c_idx;
   logic [XW-1:0]      raddr_x;
   logic [XW-1:0]      offs_x;
   logic               at_home;
   logic               last_row;
   logic               last_col;
   logic               scroll_go;
   logic [AW-1:0]      cell_addr;

   assign q_idx     = CON_W'(q_cmd.con);
   assign c_idx     = CON_W'(cmd_ff.con);
   assign raddr_x   = XW'(cmd_ff.addr);
   assign offs_x    = XW'(cell_ff);
   assign at_home   = (row_w_ff == '0) && (col_w_ff == '0);
   assign last_row  = row_w_ff == RW'(ROWS - 1);
   assign last_col  = col_w_ff == CW'(COLS - 1);
   assign scroll_go = (state_in == S_SCROLL) && (state_ff != S_SCROLL);
   assign cell_addr = base_ff + AW'(row_w_ff * COLS) + AW'(col_w_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == AW'(STORE_CELLS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (!q_empty) state_in = S_PREP;
         end
         S_PREP: begin
            unique case (cmd_ff.op) inside
               OP_READ, OP_NONE: state_in = S_RESP;
               OP_FG, OP_BG, OP_BACK: state_in = S_CURSOR;
               OP_DEL: state_in = at_home ? S_CURSOR : S_CELL_ADDR;
               OP_PUT: state_in = S_CELL_ADDR;
               OP_NEWLINE: state_in = last_row ? S_SCROLL : S_CURSOR;
               default: state_in = S_RESP;
            endcase
         end
         S_CELL_ADDR: state_in = (cmd_ff.op == OP_DEL) ? S_DEL_RD : S_PUT_WR;
         S_DEL_RD: state_in = S_DEL_WR;
         S_DEL_WR: state_in = S_CURSOR;
         S_PUT_WR: state_in = (last_col && last_row) ? S_SCROLL : S_CURSOR;
         S_SCROLL: begin
            if (i_ff == SW'(SCREEN_CELLS)) state_in = S_CURSOR;
         end
         S_CURSOR: state_in = S_RESP;
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and store port control
   always_comb begin
      q_pop             = 1'b0;
      clearing          = 1'b0;
      mem_re            = 1'b0;
      mem_raddr         = '0;
      mem_we            = 1'b0;
      mem_waddr         = '0;
      mem_wdata         = BLANK_CELL;
      rsp_strobe        = 1'b0;
      rsp_cursor_offset = '0;
      rsp_cursor_update = 1'b0;
      rsp_read_char     = '0;
      rsp_read_fg       = '0;
      rsp_read_bg       = '0;
      unique case (state_ff)
         S_CLEAR: begin
            clearing  = 1'b1;
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
         end
         S_IDLE: q_pop = ~q_empty;
         S_PREP: begin
            if (cmd_ff.op == OP_READ) begin
               mem_re    = 1'b1;
               mem_raddr = raddr_x[AW-1:0];
            end
         end
         S_DEL_RD: begin
            mem_re    = 1'b1;
            mem_raddr = cell_ff;
         end
         S_DEL_WR: begin
            mem_we    = 1'b1;
            mem_waddr = cell_ff;
            mem_wdata = {rd_data_ff[CELL_W-1:CHAR_W], CHR_SPACE};
         end
         S_PUT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = cell_ff;
            mem_wdata = {bg_ff[c_idx], fg_ff[c_idx], cmd_ff.chr};
         end
         S_SCROLL: begin
            // read one cell ahead, write the one fetched last cycle
            mem_re    = i_ff < SW'(SCREEN_CELLS);
            mem_raddr = src_ff;
            mem_we    = pend_ff;
            mem_waddr = pdst_ff;
            mem_wdata = pblank_ff ? {rd_data_ff[CELL_W-1:CHAR_W], CHR_SPACE} : rd_data_ff;
         end
         S_RESP: begin
            rsp_strobe = 1'b1;
            case (cmd_ff.op)
               OP_READ: begin
                  if (rd_ok_ff) begin
                     rsp_read_char = rd_data_ff[CHAR_W-1:0];
                     rsp_read_fg   = rd_data_ff[CHAR_W +: COLOR_W];
                     rsp_read_bg   = rd_data_ff[CHAR_W+COLOR_W +: COLOR_W];
                  end
               end
               OP_NONE: ;
               default: begin
                  if (cmd_ff.last) begin
                     rsp_cursor_offset = offs_x[RD_ADDR_W-1:0];
                     rsp_cursor_update = 1'b1;
                  end
               end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= store_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         for (int k = 0; k < CONSOLES; k++) begin
            cur_row_ff[k] <= '0;
            cur_col_ff[k] <= '0;
            fg_ff[k]      <= FG_RESET;
            bg_ff[k]      <= BG_RESET;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (state_ff == S_PREP && cmd_ff.op == OP_FG) fg_ff[c_idx] <= cmd_ff.chr[COLOR_W-1:0];
         if (state_ff == S_PREP && cmd_ff.op == OP_BG) bg_ff[c_idx] <= cmd_ff.chr[COLOR_W-1:0];
         if (state_ff == S_CURSOR) begin
            cur_row_ff[c_idx] <= row_w_ff;
            cur_col_ff[c_idx] <= col_w_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff) inside
         S_IDLE: begin
            if (!q_empty) begin
               cmd_ff   <= q_cmd;
               base_ff  <= AW'(q_idx * SCREEN_CELLS);
               row_w_ff <= cur_row_ff[q_idx];
               col_w_ff <= cur_col_ff[q_idx];
            end
         end
         S_PREP: begin
            rd_ok_ff <= raddr_x < XW'(STORE_CELLS);
            case (cmd_ff.op) inside
               OP_BACK, OP_DEL: begin
                  if (!at_home) begin
                     if (col_w_ff == '0) begin
                        col_w_ff <= CW'(COLS - 1);
                        row_w_ff <= row_w_ff - RW'(1);
                     end else begin
                        col_w_ff <= col_w_ff - CW'(1);
                     end
                  end
               end
               OP_NEWLINE: begin
                  // on the bottom row this already lands where a scroll leaves the cursor
                  col_w_ff <= '0;
                  if (!last_row) row_w_ff <= row_w_ff + RW'(1);
               end
               default: ;
            endcase
         end
         S_CELL_ADDR, S_CURSOR: cell_ff <= cell_addr;
         S_PUT_WR: begin
            if (last_col) begin
               col_w_ff <= '0;
               if (!last_row) row_w_ff <= row_w_ff + RW'(1);
            end else begin
               col_w_ff <= col_w_ff + CW'(1);
            end
         end
         S_SCROLL: begin
            pend_ff   <= i_ff < SW'(SCREEN_CELLS);
            pdst_ff   <= dst_ff;
            pblank_ff <= i_ff >= SW'(MOVED);
            if (i_ff < SW'(SCREEN_CELLS)) i_ff <= i_ff + SW'(1);
            dst_ff    <= dst_ff + AW'(1);
            // after the moved rows, re-read the bottom row in place
            if (i_ff == SW'(MOVED - 1)) begin
               src_ff <= base_ff + AW'(MOVED);
            end else begin
               src_ff <= src_ff + AW'(1);
            end
         end
         default: ;
      endcase
      if (scroll_go) begin
         i_ff     <= '0;
         src_ff   <= base_ff + AW'(COLS);
         dst_ff   <= base_ff;
         pend_ff  <= 1'b0;
      end
   end

endmodule

>>> sv/text_terminal_cell_writer.sv
// Multi-console text cell store with per-console cursor and colors.
// Command channel: a word is taken when start is high and busy is low.
//   req_func 0 hands req_data_byte to console req_console_index; 1 reads the
//   cell at req_read_address. req_last_of_write asks for the cursor report.
// Result channel: every command gives exactly one result word, shown for one
//   cycle with rsp_strobe high; the receiver cannot stall it.
// From the idle state, reads and ignored words pass through the prep and response
//   states; color codes, backspace, newline and DEL at the first cell add a
//   cursor state; printable bytes add cell-address, write and cursor states,
//   and DEL adds cell-address, read, write and cursor states. A printable byte
//   in the last cell or a newline on the bottom row adds a scroll, one cell per
//   cycle through the store's read and write ports; a two-entry queue lets new
//   commands come in while the sequencer is working.
// After reset, busy stays high while every cell is written to a white-on-black
//   space; cursors return to zero and colors to white on black.
module text_terminal_cell_writer #(
   parameter int COLS     = tcw_pkg::COLS_DEF,
   parameter int ROWS     = tcw_pkg::ROWS_DEF,
   parameter int CONSOLES = tcw_pkg::CONSOLES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_func,
   input  logic [tcw_pkg::CON_IDX_W-1:0]   req_console_index,
   input  logic [tcw_pkg::CHAR_W-1:0]      req_data_byte,
   input  logic                            req_last_of_write,
   input  logic [tcw_pkg::RD_ADDR_W-1:0]   req_read_address,
   output logic                            rsp_strobe,
   output logic [tcw_pkg::RD_ADDR_W-1:0]   rsp_cursor_offset,
   output logic                            rsp_cursor_update,
   output logic [tcw_pkg::CHAR_W-1:0]      rsp_read_char,
   output logic [tcw_pkg::COLOR_W-1:0]     rsp_read_fg,
   output logic [tcw_pkg::COLOR_W-1:0]     rsp_read_bg
);
   import tcw_pkg::*;

   logic    push;
   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    q_empty;
   logic    q_full;
   logic    q_pop;
   logic    clearing;

   assign busy = q_full | clearing;

   tcw_front #(
      .CONSOLES(CONSOLES)
   ) u_front (
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_console_index (req_console_index),
      .req_data_byte     (req_data_byte),
      .req_last_of_write (req_last_of_write),
      .req_read_address  (req_read_address),
      .push              (push),
      .cmd               (push_cmd)
   );

   tcw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   tcw_back #(
      .COLS     (COLS),
      .ROWS     (ROWS),
      .CONSOLES (CONSOLES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_cmd             (head_cmd),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .clearing          (clearing),
      .rsp_strobe        (rsp_strobe),
      .rsp_cursor_offset (rsp_cursor_offset),
      .rsp_cursor_update (rsp_cursor_update),
      .rsp_read_char     (rsp_read_char),
      .rsp_read_fg       (rsp_read_fg),
      .rsp_read_bg       (rsp_read_bg)
   );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import tcw_pkg::*;

   localparam int SCREEN_CELLS   = COLS_DEF * ROWS_DEF;
   localparam int STORE_CELLS    = SCREEN_CELLS * CONSOLES_DEF;
   localparam int ADDR_MAX       = (1 << RD_ADDR_W) - 1;
   localparam int ITEM_TARGET    = 700;
   // the limit must cover the clearing pass after reset and a scroll
   localparam int WATCHDOG_LIMIT = 100000;

   typedef struct packed {
      logic [RD_ADDR_W-1:0] offset;
      logic                 update;
      logic [CHAR_W-1:0]    chr;
      logic [COLOR_W-1:0]   fg;
      logic [COLOR_W-1:0]   bg;
   } reply_type;

   class console_tracker;
      logic [CELL_W-1:0]  cells [STORE_CELLS];
      int                 cursor [CONSOLES_DEF];
      logic [COLOR_W-1:0] fg_now [CONSOLES_DEF];
      logic [COLOR_W-1:0] bg_now [CONSOLES_DEF];
      reply_type          due_replies [$];
      int                 bad_words;

      function void power_up();
         foreach (cells[i]) cells[i] = BLANK_CELL;
         for (int c = 0; c < CONSOLES_DEF; c++) begin
            cursor[c] = 0;
            fg_now[c] = FG_RESET;
            bg_now[c] = BG_RESET;
         end
         due_replies.delete();
         bad_words = 0;
      endfunction

      function void shift_rows_up(int base, int con);
         for (int i = 0; i < SCREEN_CELLS - COLS_DEF; i++)
            cells[base + i] = cells[base + i + COLS_DEF];
         // bottom row keeps its colors, only the characters are blanked
         for (int i = SCREEN_CELLS - COLS_DEF; i < SCREEN_CELLS; i++)
            cells[base + i][CHAR_W-1:0] = CHR_SPACE;
         cursor[con] = SCREEN_CELLS - COLS_DEF;
      endfunction

      function void interpret_byte(int con, logic [CHAR_W-1:0] b);
         int base;
         int cur;
         base = con * SCREEN_CELLS;
         cur  = cursor[con];
         if (cur >= SCREEN_CELLS) cur = SCREEN_CELLS - 1;
         if (b == CHR_NEWLINE) begin
            cur = (cur / COLS_DEF + 1) * COLS_DEF;
            cursor[con] = cur;
            if (cur >= SCREEN_CELLS) shift_rows_up(base, con);
         end else if (b == CHR_DEL) begin
            if (cur > 0) begin
               cur--;
               cells[base + cur][CHAR_W-1:0] = CHR_SPACE;
            end
            cursor[con] = cur;
         end else if (b == CHR_BACK) begin
            if (cur > 0) cur--;
            cursor[con] = cur;
         end else if (b[7:4] == FG_GROUP) begin
            fg_now[con] = b[3:0];
         end else if (b[7:4] == BG_GROUP) begin
            bg_now[con] = b[3:0];
         end else begin
            cells[base + cur] = {bg_now[con], fg_now[con], b};
            cur++;
            cursor[con] = cur;
            if (cur >= SCREEN_CELLS) shift_rows_up(base, con);
         end
      endfunction

      function void take_command(logic func, logic [CON_IDX_W-1:0] con,
                                 logic [CHAR_W-1:0] b, logic last,
                                 logic [RD_ADDR_W-1:0] addr);
         reply_type r;
         int        abs_pos;
         r = '0;
         if (func == FUNC_READ) begin
            if (addr < STORE_CELLS) begin
               r.chr = cells[addr][CHAR_W-1:0];
               r.fg  = cells[addr][CHAR_W +: COLOR_W];
               r.bg  = cells[addr][CHAR_W+COLOR_W +: COLOR_W];
            end
         end else if (int'(con) < CONSOLES_DEF) begin
            interpret_byte(int'(con), b);
            if (last) begin
               abs_pos  = int'(con) * SCREEN_CELLS + cursor[con];
               r.offset = abs_pos[RD_ADDR_W-1:0];
               r.update = 1'b1;
            end
         end
         due_replies.push_back(r);
      endfunction

      function void check_reply(reply_type got);
         reply_type want;
         if (due_replies.size() == 0) begin
            bad_words++;
            if (bad_words <= 10)
               $display("unexpected reply word: off %0d upd %0b chr %02h fg %h bg %h",
                        got.offset, got.update, got.chr, got.fg, got.bg);
            return;
         end
         want = due_replies.pop_front();
         if (want !== got) begin
            bad_words++;
            if (bad_words <= 10)
               $display("reply mismatch: want off %0d upd %0b chr %02h fg %h bg %h, %s%0d %s",
                        want.offset, want.update, want.chr, want.fg, want.bg,
                        "got off ", got.offset,
                        $sformatf("upd %0b chr %02h fg %h bg %h",
                                  got.update, got.chr, got.fg, got.bg));
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_func;
   logic [CON_IDX_W-1:0] req_console_index;
   logic [CHAR_W-1:0]    req_data_byte;
   logic                 req_last_of_write;
   logic [RD_ADDR_W-1:0] req_read_address;
   logic                 rsp_strobe;
   logic [RD_ADDR_W-1:0] rsp_cursor_offset;
   logic                 rsp_cursor_update;
   logic [CHAR_W-1:0]    rsp_read_char;
   logic [COLOR_W-1:0]   rsp_read_fg;
   logic [COLOR_W-1:0]   rsp_read_bg;

   console_tracker sb;
   int             sent_count;
   int             idle_cycles;

   text_terminal_cell_writer u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_console_index (req_console_index),
      .req_data_byte     (req_data_byte),
      .req_last_of_write (req_last_of_write),
      .req_read_address  (req_read_address),
      .rsp_strobe        (rsp_strobe),
      .rsp_cursor_offset (rsp_cursor_offset),
      .rsp_cursor_update (rsp_cursor_update),
      .rsp_read_char     (rsp_read_char),
      .rsp_read_fg       (rsp_read_fg),
      .rsp_read_bg       (rsp_read_bg)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_word(logic func, logic [CON_IDX_W-1:0] con, logic [CHAR_W-1:0] b,
                            logic last, logic [RD_ADDR_W-1:0] addr);
      int idle_pct;
      idle_pct = (sent_count < ITEM_TARGET / 3)     ? 16 :
                 (sent_count < 2 * ITEM_TARGET / 3) ? 73 : 0;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start             <= 1'b1;
      req_func          <= func;
      req_console_index <= con;
      req_data_byte     <= b;
      req_last_of_write <= last;
      req_read_address  <= addr;
      do @(posedge clock); while (busy);
      sb.take_command(func, con, b, last, addr);
      sent_count++;
   endtask

   task automatic put_byte(int con, logic [CHAR_W-1:0] b, logic last);
      send_word(FUNC_WRITE, CON_IDX_W'(con), b, last,
                RD_ADDR_W'($urandom_range(0, ADDR_MAX)));
   endtask

   task automatic read_cell(int addr);
      send_word(FUNC_READ, CON_IDX_W'($urandom_range(0, CONSOLES_DEF - 1)),
                CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                RD_ADDR_W'(addr));
   endtask

   function automatic logic [CHAR_W-1:0] printable_byte();
      logic [CHAR_W-1:0] b;
      do b = CHAR_W'($urandom_range(8'h20, 8'hFF)); while (b == CHR_DEL);
      return b;
   endfunction

   // most traffic on two consoles so they reach the bottom row and scroll
   function automatic int pick_console();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 80) return CONSOLES_DEF - 1;
      return $urandom_range(0, CONSOLES_DEF - 1);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_reply({rsp_cursor_offset, rsp_cursor_update, rsp_read_char,
                         rsp_read_fg, rsp_read_bg});
   end

   initial begin : watchdog
      idle_cycles = 0;
      do begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_strobe) idle_cycles = 0;
         else idle_cycles++;
      end while (idle_cycles < WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
   end

   initial begin
      int kind;
      int con;
      int n;
      int addr;
      int r;
      logic [CHAR_W-1:0] b;

      reset             <= 1'b1;
      start             <= 1'b0;
      req_func          <= FUNC_WRITE;
      req_console_index <= '0;
      req_data_byte     <= '0;
      req_last_of_write <= 1'b0;
      req_read_address  <= '0;
      sent_count = 0;
      sb = new;
      sb.power_up();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: store corners, back steps at the first cell, every code class
      read_cell(0);
      read_cell(STORE_CELLS - 1);
      read_cell(STORE_CELLS);
      read_cell(ADDR_MAX);
      put_byte(CONSOLES_DEF - 1, CHR_DEL, 1'b1);
      put_byte(CONSOLES_DEF - 1, CHR_BACK, 1'b1);
      put_byte(0, 8'h00, 1'b0);
      put_byte(0, 8'h1F, 1'b0);
      put_byte(0, 8'h20, 1'b0);
      put_byte(0, 8'hFF, 1'b1);
      put_byte(0, 8'h80, 1'b0);
      put_byte(0, 8'h7E, 1'b1);
      put_byte(0, 8'h0F, 1'b0);
      put_byte(0, 8'h10, 1'b0);
      put_byte(0, 8'h41, 1'b1);
      put_byte(0, CHR_DEL, 1'b1);
      put_byte(0, CHR_BACK, 1'b1);
      put_byte(0, CHR_NEWLINE, 1'b1);
      for (int i = 0; i < 4; i++) read_cell(i);
      put_byte(CONSOLES_DEF - 1, 8'h5A, 1'b1);
      read_cell((CONSOLES_DEF - 1) * SCREEN_CELLS);

      while (sent_count < ITEM_TARGET) begin
         kind = $urandom_range(99);
         con  = pick_console();
         if (kind < 30) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
               put_byte(con, CHR_NEWLINE, (i == n - 1) ? 1'b1 : 1'($urandom_range(0, 1)));
         end else if (kind < 50) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
               put_byte(con, printable_byte(), (i == n - 1) ? 1'b1 : 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 1)) put_byte(con, CHR_NEWLINE, 1'b1);
         end else if (kind < 60) begin
            // fill to the end of the row; on the bottom row this scrolls
            n = COLS_DEF - sb.cursor[con] % COLS_DEF;
            for (int i = 0; i < n; i++)
               put_byte(con, printable_byte(), (i == n - 1) ? 1'b1 : 1'($urandom_range(0, 1)));
         end else if (kind < 70) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
               r = $urandom_range(2);
               if (r == 0) b = {FG_GROUP, 4'($urandom_range(0, 15))};
               else if (r == 1) b = {BG_GROUP, 4'($urandom_range(0, 15))};
               else b = CHAR_W'($urandom_range(0, 255));
               put_byte(con, b, 1'($urandom_range(0, 1)));
            end
         end else if (kind < 80) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
               put_byte(con, $urandom_range(0, 1) ? CHR_DEL : CHR_BACK,
                        (i == n - 1) ? 1'b1 : 1'($urandom_range(0, 1)));
         end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
               r = $urandom_range(9);
               if (r < 6) begin
                  addr = sb.cursor[con] - $urandom_range(0, 90);
                  if (addr < 0) addr = 0;
                  addr = con * SCREEN_CELLS + addr;
               end else if (r < 8) begin
                  addr = $urandom_range(0, STORE_CELLS - 1);
               end else begin
                  addr = $urandom_range(0, ADDR_MAX);
               end
               read_cell(addr);
            end
         end
      end
      start <= 1'b0;

      while (sb.due_replies.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.bad_words == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

>>> files.f
sv/tcw_pkg.sv
sv/tcw_front.sv
sv/tcw_queue.sv
sv/tcw_back.sv
sv/text_terminal_cell_writer.sv
verif/testbench.sv
